// File: rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and widths for the triangle face normal pipeline.
// Holds the word formats that travel between the front end, the square root
// cells and the divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    // Field widths of the input and output words.
    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_W            = NORMAL_FRAC_BITS + 2;

    // Datapath widths derived from the coordinate width.
    localparam int EW = COORD_WIDTH + 1;      // edge vector component
    localparam int PW = 2 * EW;               // edge product
    localparam int NW = PW + 1;               // cross product component
    localparam int MW = NW - 1;               // cross product magnitude
    localparam int HW = (MW + 1) / 2;         // low half of a split magnitude
    localparam int SW = 2 * MW + 2;           // sum of three squares
    localparam int LW = MW + 1;               // length (square root)
    localparam int QW = NORMAL_FRAC_BITS + 1; // quotient magnitude

    // Input word: three vertices.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_in_word;

    // Output word: unit normal and degenerate flag.
    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_out_word;

    // Word handed along the square root cells.
    typedef struct packed {
        logic signed [NW-1:0] n_x;
        logic signed [NW-1:0] n_y;
        logic signed [NW-1:0] n_z;
        logic [SW-1:0]        rad;
        logic [LW+1:0]        rem;
        logic [LW-1:0]        root;
    } t_sq_word;

    // Word handed along the divider cells.
    typedef struct packed {
        logic [LW-1:0] d;
        logic [LW-1:0] r_x;
        logic [LW-1:0] r_y;
        logic [LW-1:0] r_z;
        logic [QW-1:0] q_x;
        logic [QW-1:0] q_y;
        logic [QW-1:0] q_z;
        logic          neg_x;
        logic          neg_y;
        logic          neg_z;
        logic          degen;
    } t_dv_word;

endpackage

`default_nettype wire

// File: rtl/triangle_face_normal.sv
// Throughput: one word per cycle; every stage of the cell row moves together.
// The whole row holds while a finished word is stalled at the output register.
// Reset (synchronous, active low) clears every valid bit; the datapath keeps
// no state between words, so nothing else needs clearing.
// ----------------------------------------------------------------------------
// triangle_face_normal: unit normal of a triangle in signed Q1.14.
// Cross product of the edges, a row of square root cells for the length, and
// a row of divider cells that divide each component by the length.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal
    import tfn_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  wire       i_stall,
    output t_out_word o_data
);

    logic adv;

    t_sq_word w_sq [LW+1];
    logic     v_sq [LW+1];
    t_dv_word w_dv [QW];
    logic     v_dv [QW];

    logic      r_dv_valid;
    t_dv_word  r_dv;
    logic      r_out_valid;
    t_out_word r_out;

    t_dv_word  n_dv;
    logic [LW-1:0] n_mag [3];
    logic [LW-1:0] n_df  [3];
    logic          n_ge  [3];
    logic [NW-1:0] n_neg [3];
    logic signed [NW-1:0] n_n [3];

    logic [OUT_W-1:0] n_qe [3];
    logic [OUT_W-1:0] n_qs [3];
    logic [QW-1:0]    n_q  [3];
    logic             n_sg [3];

    // The whole row advances unless the output word is stalled.
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_word  (i_data),
        .o_valid (v_sq[0]),
        .o_word  (w_sq[0])
    );

    // Square root cell row, one root bit per cell.
    for (genvar g = 0; g < LW; g++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_sq[g]),
            .i_word  (w_sq[g]),
            .o_valid (v_sq[g+1]),
            .o_word  (w_sq[g+1])
        );
    end

    // Divider setup: magnitudes, signs and the integer quotient bit.
    always_comb begin
        n_n[0] = w_sq[LW].n_x;
        n_n[1] = w_sq[LW].n_y;
        n_n[2] = w_sq[LW].n_z;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = NW'(0) - n_n[k];
            n_mag[k] = {1'b0, (n_n[k][NW-1] ? n_neg[k][MW-1:0] : n_n[k][MW-1:0])};
            n_ge[k]  = n_mag[k] >= w_sq[LW].root;
            n_df[k]  = n_mag[k] - w_sq[LW].root;
        end
        n_dv.d     = w_sq[LW].root;
        n_dv.r_x   = n_ge[0] ? n_df[0] : n_mag[0];
        n_dv.r_y   = n_ge[1] ? n_df[1] : n_mag[1];
        n_dv.r_z   = n_ge[2] ? n_df[2] : n_mag[2];
        n_dv.q_x   = QW'(n_ge[0]);
        n_dv.q_y   = QW'(n_ge[1]);
        n_dv.q_z   = QW'(n_ge[2]);
        n_dv.neg_x = n_n[0][NW-1];
        n_dv.neg_y = n_n[1][NW-1];
        n_dv.neg_z = n_n[2][NW-1];
        n_dv.degen = w_sq[LW].root == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid <= 1'b0;
        end else if (adv) begin
            r_dv_valid <= v_sq[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv <= n_dv;
        end
    end

    assign w_dv[0] = r_dv;
    assign v_dv[0] = r_dv_valid;

    // Divider cell row, one fraction bit per cell.
    for (genvar g = 0; g < NORMAL_FRAC_BITS; g++) begin : g_div
        tfn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_dv[g]),
            .i_word  (w_dv[g]),
            .o_valid (v_dv[g+1]),
            .o_word  (w_dv[g+1])
        );
    end

    // Apply signs and force a zero normal for a degenerate triangle.
    always_comb begin
        n_q[0]  = w_dv[QW-1].q_x;
        n_q[1]  = w_dv[QW-1].q_y;
        n_q[2]  = w_dv[QW-1].q_z;
        n_sg[0] = w_dv[QW-1].neg_x;
        n_sg[1] = w_dv[QW-1].neg_y;
        n_sg[2] = w_dv[QW-1].neg_z;
        for (int k = 0; k < 3; k++) begin
            n_qe[k] = {1'b0, n_q[k]};
            n_qs[k] = w_dv[QW-1].degen ? '0 : (n_sg[k] ? OUT_W'(0) - n_qe[k] : n_qe[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= v_dv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.normal_x   <= n_qs[0];
            r_out.normal_y   <= n_qs[1];
            r_out.normal_z   <= n_qs[2];
            r_out.degenerate <= w_dv[QW-1].degen;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    // A degenerate word carries a zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.normal_x == '0 && o_data.normal_y == '0 && o_data.normal_z == '0)
        else $error("degenerate word with nonzero normal");

    // The x and y components of a unit normal stay within one.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.degenerate |->
            o_data.normal_x <= (OUT_W)'(1 << NORMAL_FRAC_BITS)
            && o_data.normal_x >= -(OUT_W)'(1 << NORMAL_FRAC_BITS)
            && o_data.normal_y <= (OUT_W)'(1 << NORMAL_FRAC_BITS)
            && o_data.normal_y >= -(OUT_W)'(1 << NORMAL_FRAC_BITS))
        else $error("normal component out of range");

    // The square root remainder never exceeds twice the root.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_sq[LW] |-> w_sq[LW].rem <= {1'b0, w_sq[LW].root, 1'b0})
        else $error("square root remainder too large");

    // A stalled output word holds the whole row, so the next word cannot slip in.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_dv))
        else $error("row moved while output stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front: edge vectors, cross product and sum of squares.
// Five register stages; each square is built from half-width partial
// products so no multiplier exceeds half the magnitude width.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_front
    import tfn_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_en,
    input  wire      i_valid,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_sq_word o_word
);

    localparam int UW = MW - HW;

    logic [4:0] r_v;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic signed [NW-1:0] r_n  [3];
    logic [MW-1:0]        r_m  [3];
    logic signed [NW-1:0] r_n4 [3];
    logic [2*UW-1:0]      r_hh [3];
    logic [MW-1:0]        r_hl [3];
    logic [2*HW-1:0]      r_ll [3];
    t_sq_word             r_out;

    logic signed [NW-1:0] n_n  [3];
    logic [MW-1:0]        n_m  [3];
    logic [NW-1:0]        n_neg [3];
    logic [SW-1:0]        n_sum;

    // Cross components from the products, with their magnitudes.
    always_comb begin
        n_n[0] = {r_p[0][PW-1], r_p[0]} - {r_p[1][PW-1], r_p[1]};
        n_n[1] = {r_p[2][PW-1], r_p[2]} - {r_p[3][PW-1], r_p[3]};
        n_n[2] = {r_p[4][PW-1], r_p[4]} - {r_p[5][PW-1], r_p[5]};
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = NW'(0) - n_n[k];
            n_m[k]   = n_n[k][NW-1] ? n_neg[k][MW-1:0] : n_n[k][MW-1:0];
        end
    end

    // Sum of squares from the partial products.
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 3; k++) begin
            n_sum = n_sum + (SW'(r_hh[k]) << (2 * HW)) + (SW'(r_hl[k]) << (HW + 1))
                    + SW'(r_ll[k]);
        end
    end

    // Valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1[0] <= {i_word.b_x[COORD_WIDTH-1], i_word.b_x}
                       - {i_word.a_x[COORD_WIDTH-1], i_word.a_x};
            r_e1[1] <= {i_word.b_y[COORD_WIDTH-1], i_word.b_y}
                       - {i_word.a_y[COORD_WIDTH-1], i_word.a_y};
            r_e1[2] <= {i_word.b_z[COORD_WIDTH-1], i_word.b_z}
                       - {i_word.a_z[COORD_WIDTH-1], i_word.a_z};
            r_e2[0] <= {i_word.c_x[COORD_WIDTH-1], i_word.c_x}
                       - {i_word.a_x[COORD_WIDTH-1], i_word.a_x};
            r_e2[1] <= {i_word.c_y[COORD_WIDTH-1], i_word.c_y}
                       - {i_word.a_y[COORD_WIDTH-1], i_word.a_y};
            r_e2[2] <= {i_word.c_z[COORD_WIDTH-1], i_word.c_z}
                       - {i_word.a_z[COORD_WIDTH-1], i_word.a_z};

            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];

            for (int k = 0; k < 3; k++) begin
                r_n[k]  <= n_n[k];
                r_m[k]  <= n_m[k];
                r_n4[k] <= r_n[k];
                r_hh[k] <= r_m[k][MW-1:HW] * r_m[k][MW-1:HW];
                r_hl[k] <= r_m[k][MW-1:HW] * r_m[k][HW-1:0];
                r_ll[k] <= r_m[k][HW-1:0] * r_m[k][HW-1:0];
            end

            r_out.n_x  <= r_n4[0];
            r_out.n_y  <= r_n4[1];
            r_out.n_z  <= r_n4[2];
            r_out.rad  <= n_sum;
            r_out.rem  <= '0;
            r_out.root <= '0;
        end
    end

    assign o_valid = r_v[4];
    assign o_word  = r_out;

endmodule

`default_nettype wire

// File: rtl/tfn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tfn_sqrt_cell: one bit of the digit-by-digit integer square root.
// Takes two radicand bits, tries the next root bit and hands the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt_cell
    import tfn_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_en,
    input  wire      i_valid,
    input  t_sq_word i_word,
    output logic     o_valid,
    output t_sq_word o_word
);

    logic     r_valid;
    t_sq_word r_word;
    t_sq_word n_word;

    logic [LW+1:0] n_rem2;
    logic [LW+1:0] n_trial;
    logic          n_ge;

    // Trial subtraction of (4 * root + 1).
    always_comb begin
        n_rem2  = {i_word.rem[LW-1:0], i_word.rad[SW-1 -: 2]};
        n_trial = {i_word.root, 2'b01};
        n_ge    = n_rem2 >= n_trial;
        n_word  = i_word;
        n_word.rad = {i_word.rad[SW-3:0], 2'b00};
        if (n_ge) begin
            n_word.rem  = n_rem2 - n_trial;
            n_word.root = {i_word.root[LW-2:0], 1'b1};
        end else begin
            n_word.rem  = n_rem2;
            n_word.root = {i_word.root[LW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// File: rtl/tfn_div_cell.sv
// ----------------------------------------------------------------------------
// tfn_div_cell: one quotient bit of three restoring divisions in parallel.
// All three components share the divisor, the length of the normal.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div_cell
    import tfn_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_en,
    input  wire      i_valid,
    input  t_dv_word i_word,
    output logic     o_valid,
    output t_dv_word o_word
);

    logic     r_valid;
    t_dv_word r_word;
    t_dv_word n_word;

    logic [LW:0] n_r2 [3];
    logic [LW:0] n_df [3];
    logic        n_ge [3];

    // Shift each remainder and subtract the divisor where it fits.
    always_comb begin
        n_r2[0] = {i_word.r_x, 1'b0};
        n_r2[1] = {i_word.r_y, 1'b0};
        n_r2[2] = {i_word.r_z, 1'b0};
        for (int k = 0; k < 3; k++) begin
            n_ge[k] = n_r2[k] >= {1'b0, i_word.d};
            n_df[k] = n_r2[k] - {1'b0, i_word.d};
        end
        n_word     = i_word;
        n_word.r_x = n_ge[0] ? n_df[0][LW-1:0] : n_r2[0][LW-1:0];
        n_word.r_y = n_ge[1] ? n_df[1][LW-1:0] : n_r2[1][LW-1:0];
        n_word.r_z = n_ge[2] ? n_df[2][LW-1:0] : n_r2[2][LW-1:0];
        n_word.q_x = {i_word.q_x[QW-2:0], n_ge[0]};
        n_word.q_y = {i_word.q_y[QW-2:0], n_ge[1]};
        n_word.q_z = {i_word.q_z[QW-2:0], n_ge[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triangle face normal pipeline.
// Streams vertex triples in random bursts against a randomly stalling
// receiver and checks every normal word against an integer predictor.
// ----------------------------------------------------------------------------

module tb_top
    import tfn_pkg::*;
;

    localparam int LATENCY   = 56;
    localparam int CYCLE_CAP = 400000;

    // Keeps the expected normals in order and checks each output word.
    class normal_scoreboard;
        t_out_word pending_normals[$];
        int        errors;

        // Integer square root by bit trial; sum of squares fits in 70 bits.
        function automatic logic [63:0] length_of(logic [127:0] sum_sq);
            logic [63:0]  root;
            logic [63:0]  trial;
            root = 0;
            for (int i = 40; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (128'(trial) * 128'(trial) <= sum_sq) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function automatic logic [OUT_W-1:0] scale_component(longint comp,
                                                             logic [63:0] len);
            logic [63:0] mag_v;
            logic [63:0] quot;
            mag_v = (comp < 0) ? 64'(-comp) : 64'(comp);
            quot  = (mag_v << NORMAL_FRAC_BITS) / len;
            if (comp < 0) begin
                quot = -quot;
            end
            return quot[OUT_W-1:0];
        endfunction

        function void note_triangle(t_in_word w);
            longint       e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
            logic [63:0]  mx, my, mz;
            logic [127:0] sum_sq;
            logic [63:0]  len;
            t_out_word    exp_w;
            e1x = longint'(w.b_x) - longint'(w.a_x);
            e1y = longint'(w.b_y) - longint'(w.a_y);
            e1z = longint'(w.b_z) - longint'(w.a_z);
            e2x = longint'(w.c_x) - longint'(w.a_x);
            e2y = longint'(w.c_y) - longint'(w.a_y);
            e2z = longint'(w.c_z) - longint'(w.a_z);
            nx = e1y * e2z - e1z * e2y;
            ny = e1z * e2x - e1x * e2z;
            nz = e1x * e2y - e1y * e2x;
            // Squares exceed 64 bits, so square the magnitudes at full width.
            mx = (nx < 0) ? 64'(-nx) : 64'(nx);
            my = (ny < 0) ? 64'(-ny) : 64'(ny);
            mz = (nz < 0) ? 64'(-nz) : 64'(nz);
            sum_sq = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
            len = length_of(sum_sq);
            exp_w = '0;
            if (len == 0) begin
                exp_w.degenerate = 1'b1;
            end else begin
                exp_w.normal_x = scale_component(nx, len);
                exp_w.normal_y = scale_component(ny, len);
                exp_w.normal_z = scale_component(nz, len);
            end
            pending_normals.insert(pending_normals.size(), exp_w);
        endfunction

        function void check_normal(t_out_word got);
            t_out_word exp_w;
            if (pending_normals.size() == 0) begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp_w = pending_normals.pop_front();
            if (got.normal_x !== exp_w.normal_x) begin
                $error("normal_x expected %0d got %0d", exp_w.normal_x, got.normal_x);
                errors++;
            end
            if (got.normal_y !== exp_w.normal_y) begin
                $error("normal_y expected %0d got %0d", exp_w.normal_y, got.normal_y);
                errors++;
            end
            if (got.normal_z !== exp_w.normal_z) begin
                $error("normal_z expected %0d got %0d", exp_w.normal_z, got.normal_z);
                errors++;
            end
            if (got.degenerate !== exp_w.degenerate) begin
                $error("degenerate expected %0b got %0b", exp_w.degenerate,
                       got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_data;

    normal_scoreboard normals_sb;
    t_in_word         tri_list[$];
    int               cycle_count;

    triangle_face_normal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Check accepted output words and count cycles toward the run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            normals_sb.check_normal(o_data);
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL triangle_face_normal");
            $finish;
        end
    end

    // The receiver stalls on its own pattern: calm stretches and busy stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if ((cycle_count / 300) % 3 == 0) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 40);
        end
    end

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'(signed'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_word random_triangle();
        t_in_word w;
        int       kind;
        w = '{pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        kind = $urandom_range(0, 19);
        // Occasionally collapse the triangle: repeated vertex or collinear points.
        if (kind == 0) begin
            w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
        end else if (kind == 1) begin
            w.c_x = w.b_x; w.c_y = w.b_y; w.c_z = w.b_z;
        end else if (kind == 2) begin
            w.b_x = w.a_x + 16'sd3; w.b_y = w.a_y + 16'sd5; w.b_z = w.a_z - 16'sd2;
            w.c_x = w.a_x + 16'sd6; w.c_y = w.a_y + 16'sd10; w.c_z = w.a_z - 16'sd4;
        end
        return w;
    endfunction

    // Append one triangle to the list of words still to send.
    function void add_triangle(t_in_word w);
        tri_list.insert(tri_list.size(), w);
    endfunction

    // Present one word and hold it until accepted.
    task automatic send_triangle(t_in_word w);
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        normals_sb.note_triangle(w);
    endtask

    task automatic send_burst_list();
        int gap;
        while (tri_list.size() > 0) begin
            int burst;
            burst = $urandom_range(1, 20);
            while (burst > 0 && tri_list.size() > 0) begin
                send_triangle(tri_list.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int wait_cycles;
        normals_sb  = new();
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed set: axis normals, extremes, degenerate cases.
        add_triangle('{0, 0, 0, 256, 0, 0, 0, 256, 0});
        add_triangle('{0, 0, 0, 0, 256, 0, 256, 0, 0});
        add_triangle('{0, 0, 0, 0, 256, 0, 0, 0, 256});
        add_triangle('{0, 0, 0, 0, 0, 256, 256, 0, 0});
        add_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_triangle('{5, 6, 7, 5, 6, 7, 1, 2, 3});
        add_triangle('{0, 0, 0, 1, 1, 1, 2, 2, 2});
        add_triangle('{-32768, -32768, -32768, 32767, -32768, -32768,
                       -32768, 32767, -32768});
        add_triangle('{32767, 32767, 32767, -32768, 32767, -32768,
                       32767, -32768, -32768});
        add_triangle('{-32768, 32767, -32768, 32767, -32768, 32767,
                       -32768, -32768, 32767});
        add_triangle('{-1, -1, -1, 32767, 32767, 32767, -32768, 0, 32767});
        add_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        add_triangle('{0, 0, 0, 1, 2, 3, 4, 5, 6});
        add_triangle('{-32768, -32768, -32768, -32768, -32768, -32768,
                       32767, 32767, 32767});
        for (int i = 0; i < 550; i++) begin
            add_triangle(random_triangle());
        end
        send_burst_list();

        wait_cycles = 0;
        while (normals_sb.pending_normals.size() > 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (normals_sb.errors == 0 && normals_sb.pending_normals.size() == 0) begin
            $display("PASS triangle_face_normal");
        end else begin
            $display("FAIL triangle_face_normal");
        end
        $finish;
    end
endmodule
